FILE: src/block_variance_peak_detector_defines.svh
// Assertion helpers shared by the checker.
`ifndef BLOCK_VARIANCE_PEAK_DETECTOR_DEFINES_SVH
`define BLOCK_VARIANCE_PEAK_DETECTOR_DEFINES_SVH

// Checked on every edge, reset included.
`define BVPD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

// Checked only while out of reset.
`define BVPD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

FILE: src/bvpd_pkg.sv
`timescale 1ns / 1ps
package bvpd_pkg;

  localparam int MAX_SAMPLES_DEF = 1024;
  localparam int SAMPLE_W        = 16;
  localparam int THR_W           = 32;
  localparam int TOTAL_W         = 11;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
  } in_word_t;

  typedef struct packed {
    logic                       peak;
    logic signed [SAMPLE_W-1:0] mean;
    logic [THR_W-1:0]           power;
    logic [TOTAL_W-1:0]         sample_total;
    logic                       overflowed;
  } out_word_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;
    logic mean_go;
    logic mean_cap;
    logic pass_rd;
    logic pow_go;
    logic emit;
  } dp_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic div_busy;
    logic rd_last;
    logic pipe_empty;
  } dp_sts_t;

endpackage

FILE: src/bvpd_div.sv
`timescale 1ns / 1ps
module bvpd_div #(
  parameter int DVD_W = 43,
  parameter int DVS_W = 11
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             busy,
  output logic [DVD_W-1:0] quotient
);
  localparam int STEP_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0]  dvd_r;
  logic [DVS_W-1:0]  rem_r;
  logic [DVS_W-1:0]  dvs_r;
  logic [STEP_W-1:0] step_r;
  logic              busy_r;
  logic [DVS_W:0]    shifted;
  logic              fits;
  logic [DVS_W:0]    diff;

  // Restoring division, one quotient bit per cycle.
  assign shifted = {rem_r, dvd_r[DVD_W-1]};
  assign fits    = (shifted >= {1'b0, dvs_r});
  assign diff    = shifted - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      step_r <= STEP_W'(DVD_W);
    end else if (busy_r) begin
      step_r <= step_r - STEP_W'(1);
      if (step_r == STEP_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[DVD_W-2:0], fits};
      rem_r <= fits ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
    end
  end

  assign busy     = busy_r;
  assign quotient = dvd_r;
endmodule

FILE: src/bvpd_datapath.sv
`timescale 1ns / 1ps
module bvpd_datapath #(
  parameter int MAX_SAMPLES = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  bvpd_pkg::in_word_t  in_data,
  input  logic                cfg_wr,
  input  logic [31:0]         cfg_data,
  input  bvpd_pkg::dp_cmd_t   cmd,
  output bvpd_pkg::dp_sts_t   sts,
  output bvpd_pkg::out_word_t out_data
);
  import bvpd_pkg::*;

  localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int AW    = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int SUM_W = SAMPLE_W + CNT_W;
  localparam int SQ_W  = 2 * SAMPLE_W + CNT_W;
  localparam int DIF_W = SAMPLE_W + 1;
  localparam int PRD_W = 2 * DIF_W;

  logic signed [SAMPLE_W-1:0] mem [MAX_SAMPLES];

  logic [THR_W-1:0]           thr_r;
  logic [CNT_W-1:0]           cnt_r;
  logic signed [SUM_W-1:0]    sum_r;
  logic                       ovf_r;
  logic signed [SAMPLE_W-1:0] mean_r;
  logic [AW-1:0]              addr_r;
  logic signed [SAMPLE_W-1:0] rdata_r;
  logic                       v1_r;
  logic [PRD_W-2:0]           prod_r;
  logic                       v2_r;
  logic [SQ_W-1:0]            acc_r;
  out_word_t                  out_r;

  logic                       full;
  logic [SUM_W-1:0]           sum_mag;
  logic [SQ_W-1:0]            dvd;
  logic                       div_busy;
  logic [SQ_W-1:0]            quo;
  logic [SAMPLE_W-1:0]        q16;
  logic signed [DIF_W-1:0]    dev;
  logic signed [PRD_W-1:0]    dev_sq;

  assign full    = (cnt_r == CNT_W'(MAX_SAMPLES));
  assign sum_mag = sum_r[SUM_W-1] ? unsigned'(-sum_r) : unsigned'(sum_r);
  assign dvd     = cmd.pow_go ? acc_r : SQ_W'(sum_mag);
  assign q16     = quo[SAMPLE_W-1:0];
  assign dev     = DIF_W'(rdata_r) - DIF_W'(mean_r);
  assign dev_sq  = dev * dev;

  bvpd_div #(
    .DVD_W (SQ_W),
    .DVS_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.mean_go | cmd.pow_go),
    .dividend (dvd),
    .divisor  (cnt_r),
    .busy     (div_busy),
    .quotient (quo)
  );

  // Sample store: one write port on load, one registered read port on the pass.
  always_ff @(posedge clk) begin
    if (cmd.load && !full) begin
      mem[cnt_r[AW-1:0]] <= in_data.sample;
    end
    if (cmd.pass_rd) begin
      rdata_r <= mem[addr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= '0;
      cnt_r <= '0;
      sum_r <= '0;
      ovf_r <= 1'b0;
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
    end else begin
      if (cfg_wr) begin
        thr_r <= cfg_data;
      end
      v1_r <= cmd.pass_rd;
      v2_r <= v1_r;
      if (cmd.emit) begin
        cnt_r <= '0;
        sum_r <= '0;
        ovf_r <= 1'b0;
      end else if (cmd.load) begin
        if (full) begin
          ovf_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + CNT_W'(1);
          sum_r <= sum_r + SUM_W'(in_data.sample);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mean_cap) begin
      mean_r <= sum_r[SUM_W-1] ? -q16 : q16;
      addr_r <= '0;
      acc_r  <= '0;
    end else begin
      if (cmd.pass_rd) begin
        addr_r <= addr_r + AW'(1);
      end
      if (v2_r) begin
        acc_r <= acc_r + SQ_W'(prod_r);
      end
    end
    // Square is never negative, so drop the sign bit.
    prod_r <= unsigned'(dev_sq[PRD_W-2:0]);
    if (cmd.emit) begin
      out_r.peak         <= (quo > SQ_W'(thr_r));
      out_r.mean         <= mean_r;
      out_r.power        <= quo[THR_W-1:0];
      out_r.sample_total <= TOTAL_W'(cnt_r);
      out_r.overflowed   <= ovf_r;
    end
  end

  assign sts.div_busy   = div_busy;
  assign sts.rd_last    = (CNT_W'(addr_r) == cnt_r - CNT_W'(1));
  assign sts.pipe_empty = !v1_r && !v2_r;
  assign out_data       = out_r;
endmodule

FILE: src/bvpd_ctrl.sv
`timescale 1ns / 1ps
module bvpd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_last,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  bvpd_pkg::dp_sts_t sts,
  output bvpd_pkg::dp_cmd_t cmd
);
  import bvpd_pkg::*;

  typedef enum logic [2:0] {
    S_LOAD,
    S_MEAN_GO,
    S_MEAN_WAIT,
    S_PASS,
    S_DRAIN,
    S_POW_GO,
    S_POW_WAIT,
    S_EMIT
  } state_t;

  state_t state_r;
  logic   out_valid_r;
  logic   out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    cmd          = '0;
    cmd.load     = (state_r == S_LOAD) && in_valid;
    cmd.mean_go  = (state_r == S_MEAN_GO);
    cmd.mean_cap = (state_r == S_MEAN_WAIT) && !sts.div_busy;
    cmd.pass_rd  = (state_r == S_PASS);
    cmd.pow_go   = (state_r == S_POW_GO);
    cmd.emit     = (state_r == S_EMIT) && out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      out_valid_r <= 1'b0;
    end else begin
      // Raise the result on hand-off; otherwise drop it once taken.
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_LOAD: begin
          if (in_valid && in_last) begin
            state_r <= S_MEAN_GO;
          end
        end
        S_MEAN_GO: begin
          state_r <= S_MEAN_WAIT;
        end
        S_MEAN_WAIT: begin
          if (!sts.div_busy) begin
            state_r <= S_PASS;
          end
        end
        S_PASS: begin
          if (sts.rd_last) begin
            state_r <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (sts.pipe_empty) begin
            state_r <= S_POW_GO;
          end
        end
        S_POW_GO: begin
          state_r <= S_POW_WAIT;
        end
        S_POW_WAIT: begin
          if (!sts.div_busy) begin
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            state_r <= S_LOAD;
          end
        end
        default: begin
          state_r <= S_LOAD;
        end
      endcase
    end
  end

  assign in_stall  = (state_r != S_LOAD);
  assign out_valid = out_valid_r;
endmodule

FILE: src/block_variance_peak_detector.sv
// A block of N samples loads at one word per cycle while in_stall is low; after
// the last word the mean division, the squared-deviation pass over the store
// and the power division run in turn; both divisions are bit-serial (one quotient
// bit per cycle). The next block cannot load until the result is handed off.
// Reset (rst_n, synchronous): clears the threshold, count, sum and overflow flag
// and drops any pending result; the sample store is not cleared.
`timescale 1ns / 1ps
module block_variance_peak_detector #(
  parameter int MAX_SAMPLES = bvpd_pkg::MAX_SAMPLES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  // Sample input channel
  input  logic                in_valid,
  output logic                in_stall,
  input  bvpd_pkg::in_word_t  in_data,
  // Result channel
  output logic                out_valid,
  input  logic                out_stall,
  output bvpd_pkg::out_word_t out_data,
  // Threshold write channel
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [31:0]         cfg_data
);
  import bvpd_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // The threshold register takes a word on any cycle. Writes are only
  // expected between blocks, so no interlock with the datapath is needed.
  assign cfg_ready = 1'b1;

  // Controller: sequences load, mean division, the squared-deviation pass,
  // the power division and the hand-off into the result register. Input
  // words are taken only while loading; a finished result waits in its own
  // register, so the next block can load while the consumer stalls.
  bvpd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_last   (in_data.last),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath: sample store, running sum, three-stage square/accumulate
  // pipeline, the shared divider and the result register.
  bvpd_datapath #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cfg_wr   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );
endmodule

FILE: src/bvpd_chk.sv
`timescale 1ns / 1ps
`include "block_variance_peak_detector_defines.svh"
module bvpd_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input bvpd_pkg::in_word_t  in_data,
  input logic                out_valid,
  input logic                out_stall
);
  import bvpd_pkg::*;

  `BVPD_ASSERT_ALWAYS(a_reset_clears_out, !rst_n |=> !out_valid, "result valid after reset")
  `BVPD_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid, "stalled result dropped")
  `BVPD_ASSERT(a_last_stall, in_valid && !in_stall && in_data.last |=> in_stall, "word after last")
  `BVPD_ASSERT(a_result_after_work, $rose(out_valid) |-> $past(in_stall), "result without work")
endmodule

bind block_variance_peak_detector bvpd_chk u_chk (.*);
